// ----- sv/wmfs_pkg.sv -----
// Package: shared constants, register map and item types of the wheel motor force step unit.
`timescale 1ns / 1ps
`default_nettype none

package wmfs_pkg;

   localparam int FRAC_BITS = 16;

   localparam int CFG_W  = 31;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;

   // register index, paddr[4:2]
   localparam logic [2:0] REG_VOLTAGE_GAIN   = 3'd0;
   localparam logic [2:0] REG_SPEED_GAIN     = 3'd1;
   localparam logic [2:0] REG_WHEEL_DIAMETER = 3'd2;
   localparam logic [2:0] REG_WHEEL_MASS     = 3'd3;
   localparam logic [2:0] REG_MAX_LAT_IMP    = 3'd4;
   localparam logic [2:0] REG_MAX_VOLTAGE    = 3'd5;

   localparam logic [1:0] DIR_STILL = 2'd0;
   localparam logic [1:0] DIR_FWD   = 2'd1;
   localparam logic [1:0] DIR_BACK  = 2'd2;

   // round(0.05 * 2^F)
   localparam int DEADBAND = ((5 << FRAC_BITS) + 50) / 100;

   localparam int REM1_W = 39 + FRAC_BITS;  // |speed| * 100 << F
   localparam int DEN1_W = 40;              // 314 * diameter
   localparam int AX_W   = 62 - FRAC_BITS;  // mass * |vel| >> F
   localparam int HI_W   = 31 - FRAC_BITS;  // bits of AX above 31
   localparam int K_W    = $clog2(HI_W + 1);
   localparam int REM2_W = 33 + FRAC_BITS;  // |torque| << (F + 1)

   // stage schedule
   localparam int ST_SPLIT  = 1;
   localparam int ST_SQUARE = 2;
   localparam int ST_SUM    = 3;
   localparam int ST_DIV1   = 2;
   localparam int ST_SQRT   = 4;
   localparam int ST_ANG    = 34;
   localparam int ST_TORQUE = 35;
   localparam int ST_OVF2   = 36;
   localparam int ST_LEN    = 36;
   localparam int ST_DIV2   = 37;
   localparam int ST_DIV3   = 37;
   localparam int NSTG      = 70;

   typedef struct packed {
      logic                     vclamp;
      logic [1:0]               dir;
      logic                     s_neg;
      logic                     vx_pos;
      logic                     vy_pos;
      logic                     kpos;
      logic                     skid;
      logic                     ovf1;
      logic                     ovf2;
      logic                     t_neg;
      logic signed [31:0]       dv;
      logic [REM1_W-1:0]        rem1;
      logic [31:0]              quo1;
      logic signed [63:0]       pv;
      logic signed [63:0]       pa;
      logic [REM2_W-1:0]        rem2;
      logic [31:0]              quo2;
      logic [AX_W-1:0]          ax;
      logic [AX_W-1:0]          ay;
      logic [30:0]              rx;
      logic [30:0]              ry;
      logic [61:0]              sqx;
      logic [61:0]              sqy;
      logic [61:0]              sql;
      logic [62:0]              rems;
      logic [31:0]              root;
      logic [31:0]              len;
      logic [61:0]              nx;
      logic [61:0]              ny;
      logic [30:0]              qx;
      logic [30:0]              qy;
      logic signed [31:0]       force_q;
      logic signed [31:0]       ix;
      logic signed [31:0]       iy;
   } pipe_type;

   typedef struct packed {
      logic signed [31:0] drive_force;
      logic signed [31:0] impulse_x;
      logic signed [31:0] impulse_y;
      logic               skidding;
      logic [1:0]         motion_direction;
      logic               voltage_clamped;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/wheel_motor_force_step_unit.sv -----
// Top level: pipelined wheel motor drive force and lateral impulse step.
//
// Input channel req_*: one wheel update per item (voltage, forward speed,
// lateral velocity). Result channel rsp_*: drive force, lateral canceling
// impulse, skid flag, motion direction and voltage clamp flag.
// Both channels move an item at an edge where valid is high and stall is low.
// The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds six
// 31-bit registers at byte addresses 0, 4, ..., 20; write them while idle.
// Structure: 70 pipeline stages and an output register. Throughput: one item per
// cycle unless req_stall holds the pipeline. The pipeline length is set by the
// bit-per-stage dividers (speed/diameter, torque/diameter, impulse rescale)
// and the bit-per-stage square root, each one stage per quotient/root bit.
// Reset: synchronous; pipeline empties, registers take their reset values.
// Rsp stall: the output register holds, the next item to leave the pipeline
// lands in a skid register, and req_stall rises with it and the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module wheel_motor_force_step_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [31:0]             req_voltage_in,
   input  wire logic signed [31:0]             req_forward_speed,
   input  wire logic signed [31:0]             req_lateral_vel_x,
   input  wire logic signed [31:0]             req_lateral_vel_y,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [31:0]                  rsp_drive_force,
   output logic signed [31:0]                  rsp_impulse_x,
   output logic signed [31:0]                  rsp_impulse_y,
   output logic                                rsp_skidding,
   output logic [1:0]                          rsp_motion_direction,
   output logic                                rsp_voltage_clamped,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [wmfs_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [wmfs_pkg::DATA_W-1:0]    pwdata,
   output logic [wmfs_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);
   import wmfs_pkg::*;

   logic [CFG_W-1:0] voltage_gain_ff;
   logic [CFG_W-1:0] speed_gain_ff;
   logic [CFG_W-1:0] wheel_diameter_ff;
   logic [CFG_W-1:0] wheel_mass_ff;
   logic [CFG_W-1:0] max_lat_imp_ff;
   logic [CFG_W-1:0] max_voltage_ff;

   logic [CFG_W-1:0]  dd_w;
   logic [DEN1_W-1:0] den1_w;
   logic              cfg_wr;

   pipe_type          pipe_ff [NSTG];
   pipe_type          pipe_in [NSTG];
   logic [NSTG-1:0]   vld_ff;
   logic              adv;

   rsp_type           last_w;
   rsp_type           out_ff;
   rsp_type           skid_ff;
   logic              out_vld_ff;
   logic              skid_vld_ff;
   logic              leave;
   logic              take;

   function automatic logic signed [31:0] sat_quo(input logic ovf, input logic [31:0] q,
                                                  input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         r = (ovf || q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q);
      end else begin
         r = (ovf || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
      end
      return r;
   endfunction

   // divide by 2^F, truncating toward zero
   function automatic logic signed [63:0] trunc_frac(input logic signed [63:0] p);
      logic signed [63:0] bias;
      bias = p[63] ? 64'((1 << FRAC_BITS) - 1) : 64'sd0;
      return (p + bias) >>> FRAC_BITS;
   endfunction

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_gain_ff   <= 31'd65536;
         speed_gain_ff     <= 31'd65536;
         wheel_diameter_ff <= 31'd65536;
         wheel_mass_ff     <= 31'd65536;
         max_lat_imp_ff    <= 31'd65536;
         max_voltage_ff    <= 31'd393216;
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_VOLTAGE_GAIN:   voltage_gain_ff   <= pwdata[CFG_W-1:0];
            REG_SPEED_GAIN:     speed_gain_ff     <= pwdata[CFG_W-1:0];
            REG_WHEEL_DIAMETER: wheel_diameter_ff <= pwdata[CFG_W-1:0];
            REG_WHEEL_MASS:     wheel_mass_ff     <= pwdata[CFG_W-1:0];
            REG_MAX_LAT_IMP:    max_lat_imp_ff    <= pwdata[CFG_W-1:0];
            REG_MAX_VOLTAGE:    max_voltage_ff    <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_VOLTAGE_GAIN:   prdata = {1'b0, voltage_gain_ff};
         REG_SPEED_GAIN:     prdata = {1'b0, speed_gain_ff};
         REG_WHEEL_DIAMETER: prdata = {1'b0, wheel_diameter_ff};
         REG_WHEEL_MASS:     prdata = {1'b0, wheel_mass_ff};
         REG_MAX_LAT_IMP:    prdata = {1'b0, max_lat_imp_ff};
         REG_MAX_VOLTAGE:    prdata = {1'b0, max_voltage_ff};
         default:            prdata = '0;
      endcase
   end

   // zero diameter counts as one LSB
   assign dd_w   = (wheel_diameter_ff == '0) ? 31'd1 : wheel_diameter_ff;
   assign den1_w = DEN1_W'(dd_w) * DEN1_W'(314);

   // ---------------- pipeline ----------------
   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   for (genvar gi = 0; gi < NSTG; gi++) begin : g_stage
      pipe_type prev_w;

      if (gi == 0) begin : g_src
         assign prev_w = '0;
      end else begin : g_src
         assign prev_w = pipe_ff[gi-1];
      end

      always_comb begin
         logic [31:0]         mag_s, mag_vx, mag_vy, mag_t;
         logic [62:0]         px, py;
         logic [HI_W-1:0]     hi;
         logic [K_W-1:0]      k;
         logic [71:0]         trial1;
         logic [63:0]         trial2, trialx, trialy, tsq;
         logic [4:0]          b1, b2, b3, bs;
         logic [62:0]         sum;
         logic signed [31:0]  mxs, ang, tq;
         logic signed [63:0]  diff;
         logic [30:0]         fx, fy;

         pipe_in[gi] = prev_w;
         mag_s  = '0; mag_vx = '0; mag_vy = '0; mag_t = '0;
         px = '0; py = '0; hi = '0; k = '0;
         trial1 = '0; trial2 = '0; trialx = '0; trialy = '0; tsq = '0;
         b1 = 5'(31 - (gi - ST_DIV1));
         b2 = 5'(31 - (gi - ST_DIV2));
         b3 = 5'(30 - (gi - ST_DIV3));
         bs = 5'(31 - (gi - ST_SQRT));
         sum = '0; mxs = '0; ang = '0; tq = '0; diff = '0; fx = '0; fy = '0;

         if (gi == 0) begin
            mxs = $signed({1'b0, max_voltage_ff});
            pipe_in[gi].dv = req_voltage_in;
            if (req_voltage_in > mxs) begin
               pipe_in[gi].dv     = mxs;
               pipe_in[gi].vclamp = 1'b1;
            end else if (req_voltage_in < -mxs) begin
               pipe_in[gi].dv     = -mxs;
               pipe_in[gi].vclamp = 1'b1;
            end
            mag_s = req_forward_speed[31] ? (~req_forward_speed + 32'd1) : req_forward_speed;
            pipe_in[gi].s_neg = req_forward_speed[31];
            pipe_in[gi].rem1  = {39'(mag_s) * 39'd100, {FRAC_BITS{1'b0}}};
            if (req_forward_speed > 32'(DEADBAND)) begin
               pipe_in[gi].dir = DIR_FWD;
            end else if (req_forward_speed < 32'(-DEADBAND)) begin
               pipe_in[gi].dir = DIR_BACK;
            end else begin
               pipe_in[gi].dir = DIR_STILL;
            end
            mag_vx = req_lateral_vel_x[31] ? (~req_lateral_vel_x + 32'd1) : req_lateral_vel_x;
            mag_vy = req_lateral_vel_y[31] ? (~req_lateral_vel_y + 32'd1) : req_lateral_vel_y;
            px = 63'(mag_vx) * 63'(wheel_mass_ff);
            py = 63'(mag_vy) * 63'(wheel_mass_ff);
            pipe_in[gi].ax     = px[AX_W+FRAC_BITS-1:FRAC_BITS];
            pipe_in[gi].ay     = py[AX_W+FRAC_BITS-1:FRAC_BITS];
            pipe_in[gi].vx_pos = !req_lateral_vel_x[31] && (req_lateral_vel_x != '0);
            pipe_in[gi].vy_pos = !req_lateral_vel_y[31] && (req_lateral_vel_y != '0);
         end

         if (gi == ST_SPLIT) begin
            pipe_in[gi].ovf1 = 72'(prev_w.rem1) >= {den1_w, 32'd0};
            // common right shift that brings both components under 2^31
            hi = prev_w.ax[AX_W-1:31] | prev_w.ay[AX_W-1:31];
            for (int j = 0; j < HI_W; j++) begin
               if (hi[j]) k = K_W'(j + 1);
            end
            pipe_in[gi].rx   = 31'(prev_w.ax >> k);
            pipe_in[gi].ry   = 31'(prev_w.ay >> k);
            pipe_in[gi].kpos = |hi;
         end

         if (gi == ST_SQUARE) begin
            pipe_in[gi].sqx = 62'(prev_w.rx) * 62'(prev_w.rx);
            pipe_in[gi].sqy = 62'(prev_w.ry) * 62'(prev_w.ry);
            pipe_in[gi].sql = 62'(max_lat_imp_ff) * 62'(max_lat_imp_ff);
         end

         if (gi == ST_SUM) begin
            sum = 63'(prev_w.sqx) + 63'(prev_w.sqy);
            pipe_in[gi].skid = prev_w.kpos || (sum > 63'(prev_w.sql));
            pipe_in[gi].rems = sum;
            pipe_in[gi].root = '0;
         end

         // restoring division |speed|*100*2^F / (314*d), one quotient bit a stage
         if (gi >= ST_DIV1 && gi < ST_DIV1 + 32) begin
            trial1 = 72'(den1_w) << b1;
            if (72'(prev_w.rem1) >= trial1) begin
               pipe_in[gi].rem1     = REM1_W'(72'(prev_w.rem1) - trial1);
               pipe_in[gi].quo1[b1] = 1'b1;
            end
         end

         // integer square root, one root bit a stage
         if (gi >= ST_SQRT && gi < ST_SQRT + 32) begin
            tsq = (64'(prev_w.root) << (bs + 1)) + (64'd1 << (2 * bs));
            if ({1'b0, prev_w.rems} >= tsq) begin
               pipe_in[gi].rems     = 63'({1'b0, prev_w.rems} - tsq);
               pipe_in[gi].root[bs] = 1'b1;
            end
         end

         if (gi == ST_ANG) begin
            ang = sat_quo(prev_w.ovf1, prev_w.quo1, prev_w.s_neg);
            pipe_in[gi].pv = $signed({1'b0, voltage_gain_ff}) * prev_w.dv;
            pipe_in[gi].pa = $signed({1'b0, speed_gain_ff}) * ang;
         end

         if (gi == ST_TORQUE) begin
            diff = trunc_frac(prev_w.pv) - trunc_frac(prev_w.pa);
            if (diff > 64'sd2147483647) begin
               tq = 32'sh7FFF_FFFF;
            end else if (diff < -64'sd2147483648) begin
               tq = 32'sh8000_0000;
            end else begin
               tq = diff[31:0];
            end
            mag_t = tq[31] ? (~tq + 32'd1) : tq;
            pipe_in[gi].t_neg = tq[31];
            pipe_in[gi].rem2  = {mag_t, {(FRAC_BITS + 1){1'b0}}};
            pipe_in[gi].quo2  = '0;
         end

         if (gi == ST_OVF2) begin
            pipe_in[gi].ovf2 = 64'(prev_w.rem2) >= {1'b0, dd_w, 32'd0};
         end

         if (gi == ST_LEN) begin
            pipe_in[gi].len = (prev_w.root == '0) ? 32'd1 : prev_w.root;
            pipe_in[gi].nx  = 62'(prev_w.rx) * 62'(max_lat_imp_ff);
            pipe_in[gi].ny  = 62'(prev_w.ry) * 62'(max_lat_imp_ff);
            pipe_in[gi].qx  = '0;
            pipe_in[gi].qy  = '0;
         end

         // |torque| * 2^(F+1) / d
         if (gi >= ST_DIV2 && gi < ST_DIV2 + 32) begin
            trial2 = 64'(dd_w) << b2;
            if (64'(prev_w.rem2) >= trial2) begin
               pipe_in[gi].rem2     = REM2_W'(64'(prev_w.rem2) - trial2);
               pipe_in[gi].quo2[b2] = 1'b1;
            end
         end

         // impulse rescale: component * limit / length, never above the limit
         if (gi >= ST_DIV3 && gi < ST_DIV3 + 31) begin
            trialx = 64'(prev_w.len) << b3;
            trialy = 64'(prev_w.len) << b3;
            if (64'(prev_w.nx) >= trialx) begin
               pipe_in[gi].nx     = 62'(64'(prev_w.nx) - trialx);
               pipe_in[gi].qx[b3] = 1'b1;
            end
            if (64'(prev_w.ny) >= trialy) begin
               pipe_in[gi].ny     = 62'(64'(prev_w.ny) - trialy);
               pipe_in[gi].qy[b3] = 1'b1;
            end
         end

         if (gi == NSTG - 1) begin
            pipe_in[gi].force_q = sat_quo(prev_w.ovf2, prev_w.quo2, prev_w.t_neg);
            fx = prev_w.skid ? prev_w.qx : prev_w.rx;
            fy = prev_w.skid ? prev_w.qy : prev_w.ry;
            // impulse opposes the velocity
            pipe_in[gi].ix = prev_w.vx_pos ? -$signed({1'b0, fx}) : $signed({1'b0, fx});
            pipe_in[gi].iy = prev_w.vy_pos ? -$signed({1'b0, fy}) : $signed({1'b0, fy});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[gi] <= 1'b0;
         end else if (adv) begin
            vld_ff[gi] <= (gi == 0) ? req_valid : vld_ff[(gi == 0) ? 0 : gi - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pipe_ff[gi] <= pipe_in[gi];
         end
      end
   end

   // ---------------- output register and skid ----------------
   always_comb begin
      last_w.drive_force      = pipe_ff[NSTG-1].force_q;
      last_w.impulse_x        = pipe_ff[NSTG-1].ix;
      last_w.impulse_y        = pipe_ff[NSTG-1].iy;
      last_w.skidding         = pipe_ff[NSTG-1].skid;
      last_w.motion_direction = pipe_ff[NSTG-1].dir;
      last_w.voltage_clamped  = pipe_ff[NSTG-1].vclamp;
   end

   assign leave = adv && vld_ff[NSTG-1];
   assign take  = out_vld_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || take) begin
         out_vld_ff  <= skid_vld_ff || leave;
         skid_vld_ff <= 1'b0;
      end else if (leave) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_ff <= skid_vld_ff ? skid_ff : last_w;
      end else if (leave) begin
         skid_ff <= last_w;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_drive_force      = out_ff.drive_force;
   assign rsp_impulse_x        = out_ff.impulse_x;
   assign rsp_impulse_y        = out_ff.impulse_y;
   assign rsp_skidding         = out_ff.skidding;
   assign rsp_motion_direction = out_ff.motion_direction;
   assign rsp_voltage_clamped  = out_ff.voltage_clamped;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds an item while output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_stall |=> !skid_vld_ff)
      else $error("skid register did not drain after output was taken");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      !skid_vld_ff && vld_ff[NSTG-1] && out_vld_ff && rsp_stall |=> skid_vld_ff)
      else $error("item leaving pipeline under stall was not caught");
`endif

endmodule

`default_nettype wire

// ----- sim/wheel_motor_force_step_unit_tb.sv -----
// Testbench: self-checking test of the wheel motor force step unit.
`timescale 1ns / 1ps

module wheel_motor_force_step_unit_tb;
   import wmfs_pkg::*;

   localparam int LATENCY = 71;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_voltage_in = '0;
   logic signed [31:0] req_forward_speed = '0;
   logic signed [31:0] req_lateral_vel_x = '0;
   logic signed [31:0] req_lateral_vel_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive_force, rsp_impulse_x, rsp_impulse_y;
   logic rsp_skidding, rsp_voltage_clamped;
   logic [1:0] rsp_motion_direction;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   wheel_motor_force_step_unit DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow copy of the register file
   logic [30:0] volt_gain_r, speed_gain_r, diam_r, mass_r, lat_lim_r, vmax_r;
   rsp_type wheel_results_q[$];
   int errors = 0;
   int hold_cycles = 0;   // long receiver hold-off
   bit busy_stall = 0;    // random receiver stall enable

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [63:0] root64(input logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic rsp_type wheel_step(input logic signed [31:0] volt, spd, lvx, lvy);
      rsp_type r;
      longint one, v, s, vx, vy, mx, ang, torque;
      logic [63:0] d, q, ax, ay, rx, ry, sum, lim, len, ms;
      int k;
      one = 64'sd1 << FRAC_BITS;
      v = volt; s = spd; vx = lvx; vy = lvy;
      mx = vmax_r;
      d = diam_r != 0 ? {33'd0, diam_r} : 64'd1;
      r.voltage_clamped = 1'b0;
      if (v > mx) begin
         v = mx; r.voltage_clamped = 1'b1;
      end else if (v < -mx) begin
         v = -mx; r.voltage_clamped = 1'b1;
      end
      ms = s < 0 ? -s : s;
      q = ((ms << FRAC_BITS) * 100) / (314 * d);
      if (s < 0) ang = q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
      else ang = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
      torque = clip32((longint'(volt_gain_r) * v) / one - (longint'(speed_gain_r) * ang) / one);
      r.drive_force = 32'(clip32((torque * (one * 2)) / longint'(d)));
      ax = ((vx < 0 ? -vx : vx) * mass_r) >> FRAC_BITS;
      ay = ((vy < 0 ? -vy : vy) * mass_r) >> FRAC_BITS;
      k = 0;
      while ((ax >> k) >= 64'd2147483648 || (ay >> k) >= 64'd2147483648) k++;
      rx = ax >> k;
      ry = ay >> k;
      sum = rx * rx + ry * ry;
      lim = lat_lim_r;
      r.skidding = (k > 0) || (sum > lim * lim);
      if (r.skidding) begin
         len = root64(sum);
         if (len == 0) len = 1;
         rx = rx * lim / len;
         ry = ry * lim / len;
      end
      r.impulse_x = vx > 0 ? -32'(rx) : 32'(rx);
      r.impulse_y = vy > 0 ? -32'(ry) : 32'(ry);
      if (s > DEADBAND) r.motion_direction = DIR_FWD;
      else if (s < -DEADBAND) r.motion_direction = DIR_BACK;
      else r.motion_direction = DIR_STILL;
      return r;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [30:0] val);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'({idx, 2'b00});
      pwdata <= {$urandom_range(0, 1) == 1, val};   // top bit ignored
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_VOLTAGE_GAIN:   volt_gain_r = val;
         REG_SPEED_GAIN:     speed_gain_r = val;
         REG_WHEEL_DIAMETER: diam_r = val;
         REG_WHEEL_MASS:     mass_r = val;
         REG_MAX_LAT_IMP:    lat_lim_r = val;
         default:            vmax_r = val;
      endcase
   endtask

   // valid stays high after the accept so the next item can follow back to back
   task automatic send_item(input logic [31:0] volt, spd, lvx, lvy, input bit gaps);
      int g;
      @(negedge clock);
      if (gaps) begin
         g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_voltage_in <= volt; req_forward_speed <= spd;
      req_lateral_vel_x <= lvx; req_lateral_vel_y <= lvy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      wheel_results_q.push_back(wheel_step(volt, spd, lvx, lvy));
   endtask

   task automatic drain();
      int n;
      n = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (wheel_results_q.size() != 0 && n < 100000) begin
         @(posedge clock); n++;
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_field();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 | $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 8000) - 4000;
         3: return $urandom_range(0, 600000) - 300000;
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wheel_results_q.size() == 0) begin
            report("unexpected item", 0, 0);
         end else begin
            w = wheel_results_q.pop_front();
            if (rsp_drive_force !== w.drive_force) report("drive_force", rsp_drive_force, w.drive_force);
            if (rsp_impulse_x !== w.impulse_x) report("impulse_x", rsp_impulse_x, w.impulse_x);
            if (rsp_impulse_y !== w.impulse_y) report("impulse_y", rsp_impulse_y, w.impulse_y);
            if (rsp_skidding !== w.skidding) report("skidding", rsp_skidding, w.skidding);
            if (rsp_motion_direction !== w.motion_direction)
               report("motion_direction", rsp_motion_direction, w.motion_direction);
            if (rsp_voltage_clamped !== w.voltage_clamped)
               report("voltage_clamped", rsp_voltage_clamped, w.voltage_clamped);
         end
      end
   end

   // receiver stall driver
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (busy_stall) begin
         rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_directed();
      logic [31:0] edges[8];
      edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'd3277, -32'sd3277, 32'd3276};
      foreach (edges[i]) send_item(edges[i], edges[i], edges[i], edges[7 - i], 1'b0);
      send_item(32'd393217, 32'd3278, 32'd0, 32'd0, 1'b0);
      send_item(-32'sd393217, -32'sd3278, 32'd70000, -32'sd70000, 1'b0);
      send_item(32'd65536, 32'd65536, 32'd40000, 32'd30000, 1'b0);
      drain();
   endtask

   task automatic test_zero_limits();
      csr_write(REG_WHEEL_DIAMETER, 31'd0);
      csr_write(REG_MAX_VOLTAGE, 31'd0);
      csr_write(REG_MAX_LAT_IMP, 31'd0);
      csr_write(REG_VOLTAGE_GAIN, 31'd0);
      csr_write(REG_SPEED_GAIN, 31'd0);
      csr_write(REG_WHEEL_MASS, 31'd0);
      send_item(32'd5, 32'd100, 32'd1, 32'd0, 1'b0);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      drain();
      csr_write(REG_VOLTAGE_GAIN, 31'h7FFF_FFFF);
      csr_write(REG_SPEED_GAIN, 31'h7FFF_FFFF);
      csr_write(REG_WHEEL_MASS, 31'h7FFF_FFFF);
      csr_write(REG_MAX_VOLTAGE, 31'h7FFF_FFFF);
      send_item(32'd0, 32'd1, 32'd1, 32'd0, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'hFEDC_BA98, 1'b0);
      drain();
   endtask

   task automatic test_random(input int n);
      for (int p = 0; p < 6; p++) begin
         csr_write(REG_VOLTAGE_GAIN, p == 0 ? 31'h7FFF_FFFF : 31'($urandom_range(0, 400000)));
         csr_write(REG_SPEED_GAIN, p == 1 ? 31'h7FFF_FFFF : 31'($urandom_range(0, 400000)));
         csr_write(REG_WHEEL_DIAMETER, p == 2 ? 31'h7FFF_FFFF : p == 3 ? 31'd1 :
                   31'($urandom_range(1, 300000)));
         csr_write(REG_WHEEL_MASS, p == 4 ? 31'h7FFF_FFFF : 31'($urandom));
         csr_write(REG_MAX_LAT_IMP, p == 5 ? 31'h7FFF_FFFF : 31'($urandom_range(0, 2000000)));
         csr_write(REG_MAX_VOLTAGE, p == 3 ? 31'd1 : 31'($urandom));
         busy_stall = (p % 2 == 1);
         for (int i = 0; i < n / 6; i++)
            send_item(rnd_field(), rnd_field(), rnd_field(), rnd_field(), p != 0);
         drain();
      end
      busy_stall = 0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 150; i++)
         send_item(rnd_field(), rnd_field(), rnd_field(), rnd_field(), 1'b0);
      drain();
   endtask

   initial begin
      volt_gain_r = 31'd65536; speed_gain_r = 31'd65536; diam_r = 31'd65536;
      mass_r = 31'd65536; lat_lim_r = 31'd65536; vmax_r = 31'd393216;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_zero_limits();
      test_backpressure();
      test_random(1080);
      if (errors == 0 && wheel_results_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/wmfs_pkg.sv
sv/wheel_motor_force_step_unit.sv
sim/wheel_motor_force_step_unit_tb.sv
